// File: rtl/fcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared constants, codes and types of the framed command parser.
// ----------------------------------------------------------------------------
package fcp_pkg;

    // Buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
    // Frame reads reach up to five entries past the start symbol
    localparam int FETCH_N      = 5;
    localparam int FETCH_W      = $clog2(FETCH_N + 1);
    localparam int FRAME_W      = $clog2(BUFFER_DEPTH + FETCH_N);

    localparam int CHAR_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int DATA_W       = 16;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROCESS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOCMD      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHARERR    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FORMAT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_SYMBOL   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] START_SYMBOL_RST = 7'd35;
    localparam logic [CFG_DATA_W-1:0] END_SYMBOL_RST   = 7'd33;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_P    = 7'h50;
    localparam logic [CHAR_W-1:0] CHAR_S    = 7'h53;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 7'h31;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
    localparam logic [BYTE_W-1:0] CHAR_MAX  = 8'd127;

    // Buffer memory access
    typedef struct packed {
        logic               rd_en;
        logic [FRAME_W-1:0] rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [CHAR_W-1:0]  wr_data;
    } mem_req_t;

endpackage

// File: rtl/fcp_buf_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_buf_mem
// Character buffer: one write and one registered read per cycle. Entries
// never written read as zero, as do addresses past the buffer end.
// ----------------------------------------------------------------------------
module fcp_buf_mem
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  fcp_pkg::mem_req_t         req,
    output logic [fcp_pkg::CHAR_W-1:0] rd_data
);

    logic [fcp_pkg::CHAR_W-1:0]      mem [fcp_pkg::BUFFER_DEPTH];
    logic [fcp_pkg::BUFFER_DEPTH-1:0] valid_reg;
    logic [fcp_pkg::CHAR_W-1:0]      rd_data_reg;
    logic [fcp_pkg::IDX_W-1:0]       rd_idx;
    logic                            rd_in_range;

    assign rd_idx      = req.rd_addr[fcp_pkg::IDX_W-1:0];
    assign rd_in_range = (req.rd_addr < fcp_pkg::FRAME_W'(fcp_pkg::BUFFER_DEPTH));
    assign rd_data     = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            if (rd_in_range && valid_reg[rd_idx])
            begin
                rd_data_reg <= mem[rd_idx];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    // reset contents are zero: track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

endmodule

// File: rtl/framed_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_parser
// Collects characters in a buffer and decodes a framed P or S command.
// ----------------------------------------------------------------------------
// Add, clear, unused and empty-buffer process items give done in the cycle
// after start. Any other process item keeps busy high through the scan,
// five frame reads and the decode, or through the scan alone when a
// symbol is missing; done rises as busy falls. Throughput: one add or
// clear item per cycle while not busy; results cannot be stalled.
// Reset (rst_n low, async): empty buffer reading as zeros, gains zero, 35 / 33.
module framed_command_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [fcp_pkg::KIND_W-1:0]          kind,
    input  logic [fcp_pkg::BYTE_W-1:0]          new_char,
    input  logic signed [fcp_pkg::DATA_W-1:0]   setpoint_in,
    input  logic signed [fcp_pkg::DATA_W-1:0]   plant_output_in,
    input  logic signed [fcp_pkg::DATA_W-1:0]   error_in,
    // result channel
    output logic                                done,
    output logic [fcp_pkg::STATUS_W-1:0]        status,
    output logic                                report_valid,
    output logic signed [fcp_pkg::DATA_W-1:0]   report_setpoint,
    output logic signed [fcp_pkg::DATA_W-1:0]   report_output,
    output logic signed [fcp_pkg::DATA_W-1:0]   report_error,
    output logic [fcp_pkg::CHAR_W-1:0]          gain_p,
    output logic [fcp_pkg::CHAR_W-1:0]          gain_i,
    output logic [fcp_pkg::CHAR_W-1:0]          gain_d,
    // configuration
    input  logic                                cfg_we,
    input  logic [fcp_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [fcp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EVAL
    } state_t;

    // control state
    state_t                          state_reg,     state_next;
    logic                            done_reg,      done_next;
    logic [fcp_pkg::STATUS_W-1:0]    status_reg,    status_next;
    logic                            rv_reg,        rv_next;
    logic [fcp_pkg::LEN_W-1:0]       len_reg,       len_next;
    logic [fcp_pkg::LEN_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [fcp_pkg::FETCH_W-1:0]     fetch_cnt_reg, fetch_cnt_next;
    logic                            pend_reg,      pend_next;
    logic                            found_s_reg,   found_s_next;
    logic                            found_e_reg,   found_e_next;
    logic [fcp_pkg::CHAR_W-1:0]      gain_p_reg,    gain_p_next;
    logic [fcp_pkg::CHAR_W-1:0]      gain_i_reg,    gain_i_next;
    logic [fcp_pkg::CHAR_W-1:0]      gain_d_reg,    gain_d_next;

    // datapath (no reset)
    logic [fcp_pkg::LEN_W-1:0]       s_pos_reg,     s_pos_next;
    logic [fcp_pkg::LEN_W-1:0]       pend_idx_reg,  pend_idx_next;
    logic [fcp_pkg::CHAR_W-1:0]      frame_reg  [fcp_pkg::FETCH_N];
    logic [fcp_pkg::CHAR_W-1:0]      frame_next [fcp_pkg::FETCH_N];
    logic signed [fcp_pkg::DATA_W-1:0] sp_reg,  sp_next;
    logic signed [fcp_pkg::DATA_W-1:0] po_reg,  po_next;
    logic signed [fcp_pkg::DATA_W-1:0] er_reg,  er_next;

    // configuration
    logic [fcp_pkg::CHAR_W-1:0]      start_sym_reg;
    logic [fcp_pkg::CHAR_W-1:0]      end_sym_reg;

    fcp_pkg::mem_req_t               mem_req;
    logic [fcp_pkg::CHAR_W-1:0]      rd_data;
    logic                            issue;

    function automatic logic is_digit19(input logic [fcp_pkg::CHAR_W-1:0] c);
        return (c >= fcp_pkg::CHAR_ONE) && (c <= fcp_pkg::CHAR_NINE);
    endfunction

    fcp_buf_mem u_buf_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Configuration registers, to be written only while idle (unenforced)
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_sym_reg <= fcp_pkg::START_SYMBOL_RST;
            end_sym_reg   <= fcp_pkg::END_SYMBOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fcp_pkg::REG_START_SYMBOL: start_sym_reg <= cfg_wdata;
                fcp_pkg::REG_END_SYMBOL:   end_sym_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // IDLE  : add/clear answer at once; process starts the scan if len > 0.
    // SCAN  : reads entries 0..len-1, one per cycle, and notes the first
    //         start symbol and whether an end symbol is present. The read
    //         data arrives in the cycle after its address (pend_reg).
    // FETCH : reads the five entries after the start symbol into a shift
    //         line; addresses past the buffer read zero.
    // EVAL  : decodes the P or S frame.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        rv_next        = rv_reg;
        len_next       = len_reg;
        scan_addr_next = scan_addr_reg;
        fetch_cnt_next = fetch_cnt_reg;
        pend_next      = 1'b0;
        found_s_next   = found_s_reg;
        found_e_next   = found_e_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        s_pos_next     = s_pos_reg;
        pend_idx_next  = pend_idx_reg;
        sp_next        = sp_reg;
        po_next        = po_reg;
        er_next        = er_reg;
        for (int i = 0; i < fcp_pkg::FETCH_N; i++)
        begin
            frame_next[i] = frame_reg[i];
        end
        issue           = 1'b0;
        mem_req         = '0;
        mem_req.wr_addr = len_reg[fcp_pkg::IDX_W-1:0];
        mem_req.wr_data = new_char[fcp_pkg::CHAR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rv_next = 1'b0;
                    unique case (kind)
                        fcp_pkg::KIND_ADD:
                        begin
                            done_next = 1'b1;
                            if (new_char > fcp_pkg::CHAR_MAX)
                            begin
                                status_next = fcp_pkg::ST_CHARERR;
                            end
                            else if (len_reg < fcp_pkg::LEN_W'(fcp_pkg::BUFFER_DEPTH))
                            begin
                                mem_req.wr_en = 1'b1;
                                len_next      = len_reg + 1'b1;
                                status_next   = fcp_pkg::ST_OK;
                            end
                            else
                            begin
                                status_next = fcp_pkg::ST_FULL;
                            end
                        end
                        fcp_pkg::KIND_PROCESS:
                        begin
                            sp_next = setpoint_in;
                            po_next = plant_output_in;
                            er_next = error_in;
                            if (len_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = fcp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                scan_addr_next = '0;
                                found_s_next   = 1'b0;
                                found_e_next   = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        fcp_pkg::KIND_CLEAR:
                        begin
                            done_next   = 1'b1;
                            status_next = fcp_pkg::ST_OK;
                            len_next    = '0;
                        end
                        default:
                        begin
                            // unused kind: no state change
                            done_next   = 1'b1;
                            status_next = fcp_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                issue           = (scan_addr_reg < len_reg);
                mem_req.rd_en   = issue;
                mem_req.rd_addr = fcp_pkg::FRAME_W'(scan_addr_reg);
                pend_next       = issue;
                pend_idx_next   = scan_addr_reg;
                if (issue)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if ((rd_data == start_sym_reg) && !found_s_reg)
                    begin
                        found_s_next = 1'b1;
                        s_pos_next   = pend_idx_reg;
                    end
                    if (rd_data == end_sym_reg)
                    begin
                        found_e_next = 1'b1;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    if (found_s_reg && found_e_reg)
                    begin
                        fetch_cnt_next = '0;
                        state_next     = S_FETCH;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = fcp_pkg::ST_FORMAT;
                        len_next    = '0;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_FETCH:
            begin
                issue           = (fetch_cnt_reg < fcp_pkg::FETCH_W'(fcp_pkg::FETCH_N));
                mem_req.rd_en   = issue;
                mem_req.rd_addr = fcp_pkg::FRAME_W'(s_pos_reg)
                                + fcp_pkg::FRAME_W'(fetch_cnt_reg)
                                + fcp_pkg::FRAME_W'(1);
                pend_next       = issue;
                if (issue)
                begin
                    fetch_cnt_next = fetch_cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    for (int i = 0; i < fcp_pkg::FETCH_N - 1; i++)
                    begin
                        frame_next[i] = frame_reg[i+1];
                    end
                    frame_next[fcp_pkg::FETCH_N-1] = rd_data;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                // frame_reg[0] is the entry right after the start symbol
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (frame_reg[0] == fcp_pkg::CHAR_P)
                begin
                    if ((frame_reg[1] == end_sym_reg) || (frame_reg[2] == end_sym_reg)
                        || (frame_reg[3] == end_sym_reg))
                    begin
                        status_next = fcp_pkg::ST_INCOMPLETE;
                        len_next    = '0;
                    end
                    else if (!is_digit19(frame_reg[1]) || !is_digit19(frame_reg[2])
                             || !is_digit19(frame_reg[3]))
                    begin
                        status_next = fcp_pkg::ST_CHARERR;
                        len_next    = '0;
                    end
                    else if (frame_reg[4] != end_sym_reg)
                    begin
                        // buffer kept
                        status_next = fcp_pkg::ST_FORMAT;
                    end
                    else
                    begin
                        gain_p_next = frame_reg[1];
                        gain_i_next = frame_reg[2];
                        gain_d_next = frame_reg[3];
                        status_next = fcp_pkg::ST_OK;
                        len_next    = '0;
                    end
                end
                else if (frame_reg[0] == fcp_pkg::CHAR_S)
                begin
                    if (frame_reg[1] != end_sym_reg)
                    begin
                        status_next = fcp_pkg::ST_FORMAT;
                    end
                    else
                    begin
                        rv_next     = 1'b1;
                        status_next = fcp_pkg::ST_OK;
                        len_next    = '0;
                    end
                end
                else
                begin
                    status_next = fcp_pkg::ST_NOCMD;
                    len_next    = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            status_reg    <= fcp_pkg::ST_OK;
            rv_reg        <= 1'b0;
            len_reg       <= '0;
            scan_addr_reg <= '0;
            fetch_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            found_s_reg   <= 1'b0;
            found_e_reg   <= 1'b0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            rv_reg        <= rv_next;
            len_reg       <= len_next;
            scan_addr_reg <= scan_addr_next;
            fetch_cnt_reg <= fetch_cnt_next;
            pend_reg      <= pend_next;
            found_s_reg   <= found_s_next;
            found_e_reg   <= found_e_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_pos_reg    <= s_pos_next;
        pend_idx_reg <= pend_idx_next;
        sp_reg       <= sp_next;
        po_reg       <= po_next;
        er_reg       <= er_next;
        for (int i = 0; i < fcp_pkg::FETCH_N; i++)
        begin
            frame_reg[i] <= frame_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign report_valid    = rv_reg;
    assign report_setpoint = rv_reg ? sp_reg : '0;
    assign report_output   = rv_reg ? po_reg : '0;
    assign report_error    = rv_reg ? er_reg : '0;
    assign gain_p          = gain_p_reg;
    assign gain_i          = gain_i_reg;
    assign gain_d          = gain_d_reg;

`ifndef SYNTH
    // a result is only given once the sequencer is back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while busy");

    // fill level never passes the buffer depth
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= fcp_pkg::LEN_W'(fcp_pkg::BUFFER_DEPTH))
        else $error("buffer length overflow");

    // add, clear and unused items answer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind != fcp_pkg::KIND_PROCESS)) |=> (done && !busy))
        else $error("add/clear item not answered in one cycle");

    // process on a filled buffer enters the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == fcp_pkg::KIND_PROCESS) && (len_reg != '0))
        |=> (busy && !done))
        else $error("process item did not start the scan");

    // a report only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && report_valid) |-> (status == fcp_pkg::ST_OK))
        else $error("report with non-ok status");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for framed_command_parser. A short scripted run walks
// every status code but ST_FULL, and every frame rule; then randomized frame
// traffic runs under several start/end symbol settings and sender idle rates.
// Each reply word is checked field by field against an in-bench parser model.
// ----------------------------------------------------------------------------
module tb;

    import fcp_pkg::*;

    // Kind 3 has no name in the package; the parser just answers OK
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [BYTE_W-1:0] C_OPEN  = {1'b0, START_SYMBOL_RST};
    localparam logic [BYTE_W-1:0] C_CLOSE = {1'b0, END_SYMBOL_RST};
    localparam logic [BYTE_W-1:0] C_P     = {1'b0, CHAR_P};
    localparam logic [BYTE_W-1:0] C_S     = {1'b0, CHAR_S};

    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASES        = 6;
    localparam int WORDS_PER_PHASE = 185;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   ch;
        logic [DATA_W-1:0]   sp;
        logic [DATA_W-1:0]   po;
        logic [DATA_W-1:0]   er;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                report;
        logic [DATA_W-1:0]   sp;
        logic [DATA_W-1:0]   po;
        logic [DATA_W-1:0]   er;
        logic [CHAR_W-1:0]   gp;
        logic [CHAR_W-1:0]   gi;
        logic [CHAR_W-1:0]   gd;
    } parser_reply_t;

    // Scripted words; pinned rows carry a status that is obvious by eye,
    // all other fields (and unpinned rows) come from the parser model.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   ch;
        logic [DATA_W-1:0]   sp;
        logic [DATA_W-1:0]   po;
        logic [DATA_W-1:0]   er;
        logic                pinned;
        logic [STATUS_W-1:0] status;
    } script_row_t;

    localparam int SCRIPT_LEN = 44;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // nothing buffered yet
        '{KIND_PROCESS, 8'h00, 16'h0, 16'h0, 16'h0, 1'b1, ST_EMPTY},
        // byte above 127 is refused
        '{KIND_ADD,     8'hFF, 16'h0, 16'h0, 16'h0, 1'b1, ST_CHARERR},
        // lone zero byte: no start, no end symbol
        '{KIND_ADD,     8'h00, 16'h0, 16'h0, 16'h0, 1'b1, ST_OK},
        '{KIND_PROCESS, 8'h00, 16'h0, 16'h0, 16'h0, 1'b1, ST_FORMAT},
        // good P frame sets the gains
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_P,     16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h31,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h39,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h35,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'h00,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        // good S frame reports the most negative, the most positive and -1 as values
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_S,     16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, ST_OK},
        // start followed by 0x7F: no command
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h7F,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'h00,   16'h0, 16'h0, 16'h0, 1'b1, ST_NOCMD},
        // S frame whose end check reads a stale '9' past the length
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_S,     16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'h00,   16'h0, 16'h0, 16'h0, 1'b1, ST_FORMAT},
        '{KIND_CLEAR,   8'h00,   16'h0, 16'h0, 16'h0, 1'b1, ST_OK},
        // end symbol inside the digit field
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_P,     16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h3A,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'h00,   16'h0, 16'h0, 16'h0, 1'b1, ST_INCOMPLETE},
        // ':' among the digits
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_P,     16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h37,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h3A,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h38,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'h00,   16'h0, 16'h0, 16'h0, 1'b1, ST_CHARERR},
        // digits fine, no end right after them: buffer kept
        '{KIND_ADD,     C_CLOSE, 16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_OPEN,  16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     C_P,     16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h32,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h33,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_ADD,     8'h34,   16'h0, 16'h0, 16'h0, 1'b0, ST_OK},
        '{KIND_PROCESS, 8'h00,   16'h0, 16'h0, 16'h0, 1'b1, ST_FORMAT},
        // unused kind
        '{KIND_UNUSED,  8'hFF,   16'h0, 16'h0, 16'h0, 1'b1, ST_OK}
    };

    // ------------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [KIND_W-1:0]          kind = '0;
    logic [BYTE_W-1:0]          new_char = '0;
    logic signed [DATA_W-1:0]   setpoint_in = '0;
    logic signed [DATA_W-1:0]   plant_output_in = '0;
    logic signed [DATA_W-1:0]   error_in = '0;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic                       report_valid;
    logic signed [DATA_W-1:0]   report_setpoint;
    logic signed [DATA_W-1:0]   report_output;
    logic signed [DATA_W-1:0]   report_error;
    logic [CHAR_W-1:0]          gain_p;
    logic [CHAR_W-1:0]          gain_i;
    logic [CHAR_W-1:0]          gain_d;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_addr = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

    framed_command_parser uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .new_char        (new_char),
        .setpoint_in     (setpoint_in),
        .plant_output_in (plant_output_in),
        .error_in        (error_in),
        .done            (done),
        .status          (status),
        .report_valid    (report_valid),
        .report_setpoint (report_setpoint),
        .report_output   (report_output),
        .report_error    (report_error),
        .gain_p          (gain_p),
        .gain_i          (gain_i),
        .gain_d          (gain_d),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Parser model: its own copy of buffer, length, gains and symbols.
    // Clearing only drops the length; old bytes stay visible to frame reads.
    // ------------------------------------------------------------------------
    logic [CHAR_W-1:0] line_mem [BUFFER_DEPTH] = '{default: '0};
    int                fill = 0;
    logic [CHAR_W-1:0] gain_p_q = '0;
    logic [CHAR_W-1:0] gain_i_q = '0;
    logic [CHAR_W-1:0] gain_d_q = '0;
    logic [CHAR_W-1:0] sym_open  = START_SYMBOL_RST;
    logic [CHAR_W-1:0] sym_close = END_SYMBOL_RST;

    parser_reply_t replies_due [$];
    parser_reply_t head_reply;
    int            fault_count = 0;
    int            words_sent = 0;
    int            gap_pct = 12;
    int            stall_cycles = 0;

    // Frame reads may run off the end of the buffer; those see zero
    function automatic logic [CHAR_W-1:0] peek(int idx);
        if (idx < BUFFER_DEPTH)
            return line_mem[idx];
        return '0;
    endfunction

    function automatic bit is_gain_digit(logic [CHAR_W-1:0] c);
        return c >= CHAR_ONE && c <= CHAR_NINE;
    endfunction

    // Apply one accepted command word to the model and return its reply
    function automatic parser_reply_t parse_word(cmd_word_t w);
        parser_reply_t     r;
        int                s;
        bit                got_open;
        bit                got_close;
        logic [CHAR_W-1:0] c1, c2, c3, c4, c5;
        r = '0;
        s = 0;
        got_open = 1'b0;
        got_close = 1'b0;
        case (w.kind)
            KIND_ADD:
            begin
                if (w.ch > CHAR_MAX)
                    r.status = ST_CHARERR;
                else if (fill < BUFFER_DEPTH)
                begin
                    line_mem[fill] = w.ch[CHAR_W-1:0];
                    fill++;
                end
                else
                    r.status = ST_FULL;
            end
            KIND_PROCESS:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // scan downward so the first start symbol wins
                    for (int k = fill - 1; k >= 0; k--)
                    begin
                        if (peek(k) == sym_open)
                        begin
                            s = k;
                            got_open = 1'b1;
                        end
                        if (peek(k) == sym_close)
                            got_close = 1'b1;
                    end
                    c1 = peek(s + 1);
                    c2 = peek(s + 2);
                    c3 = peek(s + 3);
                    c4 = peek(s + 4);
                    c5 = peek(s + 5);
                    if (!got_open || !got_close)
                    begin
                        fill = 0;
                        r.status = ST_FORMAT;
                    end
                    else if (c1 == CHAR_P)
                    begin
                        if (c2 == sym_close || c3 == sym_close || c4 == sym_close)
                        begin
                            fill = 0;
                            r.status = ST_INCOMPLETE;
                        end
                        else if (!is_gain_digit(c2) || !is_gain_digit(c3)
                                 || !is_gain_digit(c4))
                        begin
                            fill = 0;
                            r.status = ST_CHARERR;
                        end
                        else if (c5 != sym_close)
                            r.status = ST_FORMAT;   // buffer kept
                        else
                        begin
                            gain_p_q = c2;
                            gain_i_q = c3;
                            gain_d_q = c4;
                            fill = 0;
                        end
                    end
                    else if (c1 == CHAR_S)
                    begin
                        if (c2 != sym_close)
                            r.status = ST_FORMAT;   // buffer kept
                        else
                        begin
                            r.report = 1'b1;
                            fill = 0;
                        end
                    end
                    else
                    begin
                        fill = 0;
                        r.status = ST_NOCMD;
                    end
                end
            end
            KIND_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        if (r.report)
        begin
            r.sp = w.sp;
            r.po = w.po;
            r.er = w.er;
        end
        r.gp = gain_p_q;
        r.gi = gain_i_q;
        r.gd = gain_d_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reply checking
    // ------------------------------------------------------------------------
    task automatic note_fault(string msg);
        fault_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            note_fault($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    // done is a one-cycle strobe; the receiver cannot push back
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
                note_fault($sformatf("reply word with none pending, status %0d", status));
            else
            begin
                head_reply = replies_due.pop_front();
                check_field("status",          16'(status),          16'(head_reply.status));
                check_field("report_valid",    16'(report_valid),    16'(head_reply.report));
                check_field("report_setpoint", 16'(report_setpoint), head_reply.sp);
                check_field("report_output",   16'(report_output),   head_reply.po);
                check_field("report_error",    16'(report_error),    head_reply.er);
                check_field("gain_p",          16'(gain_p),          16'(head_reply.gp));
                check_field("gain_i",          16'(gain_i),          16'(head_reply.gi));
                check_field("gain_d",          16'(gain_d),          16'(head_reply.gd));
            end
        end
    end

    // Watchdog: any cycle with a handshake on either side restarts the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, stall_cycles);
            $display("framed_command_parser test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Hold start high until the parser takes the word; the reply is
    // predicted once busy is low again, so the model tracks the RTL order.
    task automatic issue_word(cmd_word_t w, bit pinned, logic [STATUS_W-1:0] pin_status);
        parser_reply_t r;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        kind            <= w.kind;
        new_char        <= w.ch;
        setpoint_in     <= w.sp;
        plant_output_in <= w.po;
        error_in        <= w.er;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = parse_word(w);
        if (pinned)
            r.status = pin_status;
        replies_due.push_back(r);
        if (w.kind != KIND_UNUSED)
            words_sent++;
    endtask

    // Random process values ride along with every word
    task automatic send_kind(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] c);
        cmd_word_t w;
        w.kind = k;
        w.ch   = c;
        w.sp   = 16'($urandom());
        w.po   = 16'($urandom());
        w.er   = 16'($urandom());
        issue_word(w, 1'b0, ST_OK);
    endtask

    // Stop sending until every reply is back, then let the parser settle
    task automatic hold_until_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while idle: both symbol registers, back to back
    task automatic write_symbols(logic [CHAR_W-1:0] open_sym, logic [CHAR_W-1:0] close_sym);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_START_SYMBOL;
        cfg_wdata <= open_sym;
        @(posedge clk);
        sym_open = open_sym;
        cfg_addr  <= REG_END_SYMBOL;
        cfg_wdata <= close_sym;
        @(posedge clk);
        sym_close = close_sym;
        cfg_we    <= 1'b0;
    endtask

    // Bytes biased toward the ones that steer the frame decoder
    function automatic logic [BYTE_W-1:0] pick_char();
        case ($urandom_range(7))
            0:       return {1'b0, sym_open};
            1:       return {1'b0, sym_close};
            2:       return C_P;
            3:       return C_S;
            4, 5:    return 8'($urandom_range(8'h3A, 8'h30));   // '0'..':'
            default: return 8'($urandom_range(CHAR_MAX));
        endcase
    endfunction

    // One random burst: mostly P/S frames with random content, some of them
    // damaged, plus overflow runs, broken frames and raw noise.
    task automatic run_sequence();
        logic [BYTE_W-1:0] frame [$];
        int                pick;
        bit                framed;
        pick = $urandom_range(99);
        framed = 1'b1;
        if ($urandom_range(99) < 3)
            hold_until_quiet();
        if (pick < 34)
        begin
            repeat ($urandom_range(2)) frame.push_back(pick_char());
            frame.push_back({1'b0, sym_open});
            frame.push_back(C_P);
            repeat (3) frame.push_back(8'($urandom_range(CHAR_NINE, CHAR_ONE)));
            frame.push_back({1'b0, sym_close});
        end
        else if (pick < 60)
        begin
            repeat ($urandom_range(2)) frame.push_back(pick_char());
            frame.push_back({1'b0, sym_open});
            frame.push_back(C_S);
            frame.push_back({1'b0, sym_close});
        end
        else if (pick < 68)
        begin
            // may run past the buffer depth
            repeat ($urandom_range(20, 12)) frame.push_back(pick_char());
        end
        else if (pick < 80)
        begin
            frame.push_back({1'b0, sym_open});
            repeat ($urandom_range(4)) frame.push_back(pick_char());
            if ($urandom_range(1) == 1)
                frame.push_back({1'b0, sym_close});
        end
        else if (pick < 94)
        begin
            framed = 1'b0;
            repeat ($urandom_range(6, 1))
                send_kind(2'($urandom_range(3)), 8'($urandom()));
        end
        else
        begin
            framed = 1'b0;
            send_kind(($urandom_range(1) == 1) ? KIND_PROCESS : KIND_CLEAR, 8'($urandom()));
        end

        if (framed)
        begin
            // damage the byte run now and then
            if ($urandom_range(99) < 20)
                frame[$urandom_range(frame.size() - 1)] = pick_char();
            if ($urandom_range(99) < 8)
                void'(frame.pop_back());
            foreach (frame[i])
                send_kind(KIND_ADD, frame[i]);
            pick = $urandom_range(99);
            if (pick < 85)
                send_kind(KIND_PROCESS, 8'($urandom()));
            else if (pick < 90)
                send_kind(KIND_CLEAR, 8'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main flow: reset, scripted words, then randomized phases
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_word_t         w;
        logic [CHAR_W-1:0] shared_sym;
        int                goal;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted part runs on the reset symbols '#' and '!'
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            w.kind = SCRIPT[i].kind;
            w.ch   = SCRIPT[i].ch;
            w.sp   = SCRIPT[i].sp;
            w.po   = SCRIPT[i].po;
            w.er   = SCRIPT[i].er;
            issue_word(w, SCRIPT[i].pinned, SCRIPT[i].status);
        end

        // Each phase drains first, so every symbol write lands while idle.
        // Sender idles 12% in phases 0-1, 51% in 2-3, never in 4-5.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            hold_until_quiet();
            case (ph)
                0:       write_symbols(START_SYMBOL_RST, END_SYMBOL_RST);
                1:       write_symbols(7'h00, 7'h7F);
                2:       write_symbols(7'h7F, 7'h00);
                3:
                begin
                    // one code opens and closes the frame
                    shared_sym = 7'($urandom());
                    write_symbols(shared_sym, shared_sym);
                end
                default: write_symbols(7'($urandom()), 7'($urandom()));
            endcase
            gap_pct = (ph < 2) ? 12 : (ph < 4) ? 51 : 0;
            goal = words_sent + WORDS_PER_PHASE;
            while (words_sent < goal)
                run_sequence();
        end

        hold_until_quiet();
        if (fault_count == 0 && replies_due.size() == 0)
            $display("framed_command_parser test passed");
        else
            $display("framed_command_parser test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/fcp_pkg.sv
rtl/fcp_buf_mem.sv
rtl/framed_command_parser.sv
tb/sv/tb.sv
